// File: sv/dosd_pkg.sv
// Shared constants, result codes and result record for the DER OID stream decoder.
`default_nettype none

package dosd_pkg;

    // Widest arc that is kept without saturation
    localparam int ARC_WIDTH     = 64;
    // Width of the declared length and of the content counter
    localparam int LEN_WIDTH     = 32;
    // Most long-form length octets that are taken as length
    localparam int LEN_BYTES_MAX = 4;

    // Port field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 64;
    localparam int ERR_W    = 3;
    localparam int M_DATA_W = 72;   // value and error code, padded to whole bytes

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CLASS  = 2'd0,
        KIND_ARC    = 2'd1,
        KIND_END_OK = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    // Error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_LEN      = 3'd1,
        ERR_INCOMPL  = 3'd2,
        ERR_SHORT    = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_t;

    // One result transaction
    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        err_t                 err;
        logic                 run_end;
    } res_t;

endpackage

`default_nettype wire

// File: sv/der_oid_stream_decoder_unit.sv
// Top level of the DER OID stream decoder: per-octet decode and result queue.
//
//  channel | ports                        | payload
//  --------+------------------------------+-------------------------------------
//  input   | s_tvalid s_tready s_tdata    | s_tdata: byte_in; s_tlast: final_byte
//          | s_tlast                      |
//  result  | m_tvalid m_tready m_tdata    | m_tuser: kind; m_tdata: value,
//          | m_tuser m_tlast              | error_code; m_tlast: run_end
//
// One octet is decoded in the cycle it is accepted; its zero to three results are
// written at once into a four-entry result queue and leave it one per cycle while
// m_tready is high. If the queue was empty, the first is offered the next cycle.
// s_tready is high while the queue has room for three results, so octets flow
// at one per cycle as long as results are taken about as fast as they appear.
// aresetn is synchronous, active low, and clears decode state and the queue.
// A stalled result side stops input as soon as two results wait in the queue.
`default_nettype none

module der_oid_stream_decoder_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [dosd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
    input  wire                          s_tlast,   // final_byte
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [dosd_pkg::M_DATA_W-1:0] m_tdata,  // [63:0] value, [66:64] error_code
    output logic [dosd_pkg::KIND_W-1:0]  m_tuser,   // [1:0] kind
    output logic                         m_tlast    // run_end
);
    import dosd_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int MAX_RES    = 3;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_LEN   = 2'd1,
        PH_FIRST = 2'd2,
        PH_ARC   = 2'd3
    } phase_t;

    // Decode state
    phase_t                phase_reg,       phase_next;
    logic [6:0]            len_exp_reg,     len_exp_next;
    logic [2:0]            len_seen_reg,    len_seen_next;
    logic [LEN_WIDTH-1:0]  decl_len_reg,    decl_len_next;
    logic [LEN_WIDTH-1:0]  content_cnt_reg, content_cnt_next;
    logic [ARC_WIDTH-1:0]  arc_accum_reg,   arc_accum_next;
    logic                  sub80_reg,       sub80_next;
    logic                  field_done_reg,  field_done_next;
    logic                  ovf_reg,         ovf_next;

    // Result queue
    res_t                  fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg,  count_next;

    // Decode scratch
    logic                  s_accept;
    logic                  m_accept;
    logic [7:0]            in_byte;
    logic [2:0]            len_lim;
    logic [2:0]            seen_inc;
    logic [ARC_WIDTH-1:0]  arc_val;
    logic [7:0]            first_rem;
    err_t                  end_code;
    res_t                  push_res [MAX_RES];
    logic [1:0]            push_cnt;
    res_t                  head;

    assign s_accept = s_tvalid & s_tready;
    assign m_accept = m_tvalid & m_tready;
    assign in_byte  = s_tdata;
    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES));

    assign len_lim  = (len_exp_reg < 7'(LEN_BYTES_MAX)) ? len_exp_reg[2:0]
                                                        : 3'(LEN_BYTES_MAX);
    assign seen_inc = len_seen_reg + 3'd1;
    assign first_rem = (in_byte >= 8'd40) ? (in_byte - 8'd40) : in_byte;

    // Decode one octet: next state and results
    always_comb begin
        phase_next       = phase_reg;
        len_exp_next     = len_exp_reg;
        len_seen_next    = len_seen_reg;
        decl_len_next    = decl_len_reg;
        content_cnt_next = content_cnt_reg;
        arc_accum_next   = arc_accum_reg;
        sub80_next       = sub80_reg;
        field_done_next  = field_done_reg;
        ovf_next         = ovf_reg;
        arc_val          = '0;
        end_code         = ERR_NONE;
        push_cnt         = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            push_res[i] = '{kind: KIND_CLASS, value: '0, err: ERR_NONE, run_end: 1'b0};
        end

        case (phase_reg)
            PH_TAG: begin
                push_res[0].kind  = KIND_CLASS;
                push_res[0].value = VALUE_W'(in_byte[7:6]);
                push_cnt          = 2'd1;
                phase_next        = PH_LEN;
                field_done_next   = 1'b0;
            end
            PH_LEN: begin
                if (len_exp_reg == 7'd0) begin
                    if (!in_byte[7]) begin
                        decl_len_next   = LEN_WIDTH'(in_byte);
                        phase_next      = PH_FIRST;
                        field_done_next = 1'b1;
                    end else begin
                        len_exp_next    = in_byte[6:0];
                        len_seen_next   = 3'd0;
                        decl_len_next   = '0;
                        if (in_byte[6:0] == 7'd0) begin
                            phase_next      = PH_FIRST;
                            field_done_next = 1'b1;
                        end else begin
                            field_done_next = 1'b0;
                        end
                    end
                end else begin
                    // Shift in a length octet, saturating at the counter width
                    if ((decl_len_reg >> (LEN_WIDTH - 8)) != '0) begin
                        decl_len_next = '1;
                    end else begin
                        decl_len_next = LEN_WIDTH'({decl_len_reg, in_byte});
                    end
                    len_seen_next = seen_inc;
                    if (seen_inc >= len_lim) begin
                        phase_next      = PH_FIRST;
                        field_done_next = 1'b1;
                    end
                end
            end
            PH_FIRST: begin
                if (content_cnt_reg != '1) begin
                    content_cnt_next = content_cnt_reg + 1'b1;
                end
                push_res[0].kind = KIND_ARC;
                push_res[1].kind = KIND_ARC;
                if (in_byte < 8'd80) begin
                    push_res[0].value = VALUE_W'(in_byte >= 8'd40);
                    push_res[1].value = VALUE_W'(first_rem);
                    push_cnt          = 2'd2;
                    field_done_next   = 1'b1;
                end else if (!in_byte[7]) begin
                    push_res[0].value = VALUE_W'(2);
                    push_res[1].value = VALUE_W'(in_byte - 8'd80);
                    push_cnt          = 2'd2;
                    field_done_next   = 1'b1;
                end else begin
                    push_res[0].value = VALUE_W'(2);
                    push_cnt          = 2'd1;
                    arc_accum_next    = ARC_WIDTH'(in_byte[6:0]);
                    sub80_next        = 1'b1;
                    field_done_next   = 1'b0;
                end
                phase_next = PH_ARC;
            end
            PH_ARC: begin
                if (content_cnt_reg != '1) begin
                    content_cnt_next = content_cnt_reg + 1'b1;
                end
                // Shift in seven bits, saturating on overflow
                if (arc_accum_reg[ARC_WIDTH-1 -: 7] != 7'd0) begin
                    ovf_next = 1'b1;
                    arc_val  = '1;
                end else begin
                    arc_val  = {arc_accum_reg[ARC_WIDTH-8:0], in_byte[6:0]};
                end
                arc_accum_next = arc_val;
                if (in_byte[7]) begin
                    field_done_next = 1'b0;
                end else begin
                    push_res[0].kind = KIND_ARC;
                    if (sub80_reg) begin
                        push_res[0].value = (arc_val >= ARC_WIDTH'(80))
                                          ? VALUE_W'(arc_val - ARC_WIDTH'(80)) : '0;
                    end else begin
                        push_res[0].value = VALUE_W'(arc_val);
                    end
                    push_cnt        = 2'd1;
                    arc_accum_next  = '0;
                    sub80_next      = 1'b0;
                    field_done_next = 1'b1;
                end
            end
            default: begin
                phase_next = PH_TAG;
            end
        endcase

        // Close the encoding on its last octet
        if (s_tlast) begin
            if (phase_reg == PH_TAG) begin
                end_code = ERR_SHORT;
            end else if (phase_next == PH_LEN) begin
                end_code = ERR_INCOMPL;
            end else if (len_exp_next > 7'(LEN_BYTES_MAX)
                         || decl_len_next != content_cnt_next) begin
                end_code = ERR_LEN;
            end else if (!field_done_next) begin
                end_code = ERR_INCOMPL;
            end else if (ovf_next) begin
                end_code = ERR_OVERFLOW;
            end
            push_res[push_cnt].kind  = (end_code == ERR_NONE) ? KIND_END_OK : KIND_ERROR;
            push_res[push_cnt].value = '0;
            push_res[push_cnt].err   = end_code;
            push_cnt                 = push_cnt + 2'd1;

            phase_next       = PH_TAG;
            len_exp_next     = '0;
            len_seen_next    = '0;
            decl_len_next    = '0;
            content_cnt_next = '0;
            arc_accum_next   = '0;
            sub80_next       = 1'b0;
            field_done_next  = 1'b0;
            ovf_next         = 1'b0;
        end

        // Mark the last result of this octet
        if (push_cnt != 2'd0) begin
            push_res[push_cnt - 2'd1].run_end = 1'b1;
        end
    end

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        if (s_accept) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
            count_next  = count_reg + CNT_W'(push_cnt);
        end
        if (m_accept) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    // Hold decode state and queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TAG;
            len_exp_reg     <= '0;
            len_seen_reg    <= '0;
            decl_len_reg    <= '0;
            content_cnt_reg <= '0;
            arc_accum_reg   <= '0;
            sub80_reg       <= 1'b0;
            field_done_reg  <= 1'b0;
            ovf_reg         <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            if (s_accept) begin
                phase_reg       <= phase_next;
                len_exp_reg     <= len_exp_next;
                len_seen_reg    <= len_seen_next;
                decl_len_reg    <= decl_len_next;
                content_cnt_reg <= content_cnt_next;
                arc_accum_reg   <= arc_accum_next;
                sub80_reg       <= sub80_next;
                field_done_reg  <= field_done_next;
                ovf_reg         <= ovf_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write results into the queue
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (2'(i) < push_cnt) begin
                    fifo_reg[wr_ptr_reg + PTR_W'(i)] <= push_res[i];
                end
            end
        end
    end

    // Drive the result channel from the queue head
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = head.kind;
    assign m_tdata  = M_DATA_W'({head.err, head.value});
    assign m_tlast  = head.run_end;

endmodule

`default_nettype wire

// File: sv/dosd_checker.sv
// Port-level checker for the DER OID stream decoder, bound to its top level.
`default_nettype none

module dosd_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           s_tlast,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [dosd_pkg::M_DATA_W-1:0]  m_tdata,
    input wire [dosd_pkg::KIND_W-1:0]    m_tuser,
    input wire                           m_tlast
);
    import dosd_pkg::*;

    logic s_accept;
    assign s_accept = s_tvalid & s_tready;

    // A stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // An end result closes the run of its octet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_END_OK || m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("end result without run end");

    // An error carries a nonzero code and no value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR
        |-> m_tdata[66:64] != ERR_NONE && m_tdata[63:0] == '0)
        else $error("malformed error result");

    // A class result holds a two-bit class and no error code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_CLASS |-> m_tdata[66:2] == '0)
        else $error("malformed class result");

    // An accepted last octet always yields a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> m_tvalid)
        else $error("last octet produced no result");

endmodule

bind der_oid_stream_decoder_unit dosd_checker u_dosd_checker (.*);

`default_nettype wire
